// ----- hw/rtl/ofbr_pkg.sv -----
// Shared sizes, command codes and index helpers for the overwriting byte ring FIFO.
// No dependencies; the interfaces and the top refer to it by scoped names.
`timescale 1ns / 1ps

package ofbr_pkg;

  // Storage geometry and take limit
  localparam int unsigned DEPTH    = 256;
  localparam int unsigned MAX_TAKE = 64;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned FW       = $clog2(DEPTH + 1);
  localparam int unsigned RW       = $clog2(MAX_TAKE + 1);

  // Port field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned LEVEL_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_TAKE  = 3'd1,
    CMD_DROP  = 3'd2,
    CMD_FLUSH = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TAKE = 2'b10
  } state_e;

  typedef enum logic {
    STAT_OK    = 1'b0,
    STAT_RANGE = 1'b1
  } stat_e;

  // Advance a ring index with wrap at DEPTH
  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

// ----- hw/rtl/ofbr_in_if.sv -----
// Input channel of the byte ring FIFO: valid/ready handshake and one command item.
// Field widths come from ofbr_pkg.
`timescale 1ns / 1ps

interface ofbr_in_if;
  logic                           valid;
  logic                           ready;
  logic [ofbr_pkg::CMD_W-1:0]     command;
  logic [ofbr_pkg::BYTE_W-1:0]    push_byte;
  logic [ofbr_pkg::COUNT_W-1:0]   take_count;

  modport source (output valid, output command, output push_byte, output take_count,
                  input ready);
  modport sink   (input valid, input command, input push_byte, input take_count,
                  output ready);
endinterface

// ----- hw/rtl/ofbr_out_if.sv -----
// Output channel of the byte ring FIFO: valid/ready handshake and one result item.
// Field widths come from ofbr_pkg.
`timescale 1ns / 1ps

interface ofbr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [ofbr_pkg::BYTE_W-1:0]    data_byte;
  logic [ofbr_pkg::LEVEL_W-1:0]   fill_level;
  logic                           last;

  modport source (output valid, output status, output data_byte, output fill_level,
                  output last, input ready);
  modport sink   (input valid, input status, input data_byte, input fill_level,
                  input last, output ready);
endinterface

// ----- hw/rtl/ofbr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps

module ofbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write and read ports
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/overwriting_byte_ring_fifo_top.sv -----
// Overwriting byte ring FIFO: index and count control around one storage RAM.
// Depends on ofbr_pkg, ofbr_in_if, ofbr_out_if and ofbr_ram.
//
//   port   | direction | handshake     | payload
//   in_i   | sink      | valid / ready | command, push_byte, take_count
//   out_o  | source    | valid / ready | status, data_byte, fill_level, last
//
// Push, drop, flush, query and a refused take: one result each.
// A take of N bytes: the accept cycle issues the first RAM read, then N bytes follow,
// one byte per cycle unless out_o.ready stalls, paced by the registered RAM read.
// in_i.ready is low while a take streams and while a result waits in the output
// register that out_o.ready does not take; a stall holds the RAM read data.
// Reset clears the indices, the fill count and the output valid; storage is not
// cleared, since a take only reads entries already written.
`timescale 1ns / 1ps

module overwriting_byte_ring_fifo_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  ofbr_in_if.sink           in_i,
  ofbr_out_if.source        out_o
);

  localparam int unsigned AW = ofbr_pkg::AW;
  localparam int unsigned FW = ofbr_pkg::FW;
  localparam int unsigned RW = ofbr_pkg::RW;

  ofbr_pkg::state_e state_q, state_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [RW-1:0] rem_q, rem_d;

  logic                                out_valid_q, out_valid_d;
  logic                                out_stat_q, out_stat_d;
  logic [ofbr_pkg::BYTE_W-1:0]         out_data_q, out_data_d;
  logic [ofbr_pkg::LEVEL_W-1:0]        out_fill_q, out_fill_d;
  logic                                out_last_q, out_last_d;

  logic                        load_ok, accept, load, ld_stat, ld_last, take_bad;
  logic [ofbr_pkg::BYTE_W-1:0] ld_data;
  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr;
  logic [ofbr_pkg::BYTE_W-1:0] rd_data;
  ofbr_pkg::cmd_e              cmd;

  // Storage; a write lands at the edge, so a read in any later cycle sees it
  ofbr_ram #(
    .Width (ofbr_pkg::BYTE_W),
    .Depth (ofbr_pkg::DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_idx_q),
    .wr_data_i (in_i.push_byte),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Handshake
  assign load_ok   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ofbr_pkg::ST_IDLE) && load_ok;
  assign accept    = in_i.valid && in_i.ready;
  assign cmd       = ofbr_pkg::cmd_e'(in_i.command);

  // Refuse a take of zero, above depth, above the take limit or above the fill
  assign take_bad = (in_i.take_count == '0)
                 || (32'(in_i.take_count) > ofbr_pkg::DEPTH)
                 || (32'(in_i.take_count) > ofbr_pkg::MAX_TAKE)
                 || (32'(in_i.take_count) > 32'(fill_q));

  // Command decode and take sequencer
  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    rd_en       = 1'b0;
    rd_addr     = rd_idx_q;
    wr_en       = 1'b0;
    load        = 1'b0;
    ld_stat     = ofbr_pkg::STAT_OK;
    ld_data     = '0;
    ld_last     = 1'b1;
    out_valid_d = out_valid_q && !out_o.ready;
    out_stat_d  = out_stat_q;
    out_data_d  = out_data_q;
    out_fill_d  = out_fill_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ofbr_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            ofbr_pkg::CMD_PUSH: begin
              wr_en    = 1'b1;
              wr_idx_d = ofbr_pkg::next_idx(wr_idx_q);
              if (32'(fill_q) < ofbr_pkg::DEPTH) begin
                fill_d = fill_q + 1'b1;
              end else begin
                rd_idx_d = ofbr_pkg::next_idx(rd_idx_q);
              end
              load = 1'b1;
            end
            ofbr_pkg::CMD_TAKE: begin
              if (take_bad) begin
                ld_stat = ofbr_pkg::STAT_RANGE;
                load    = 1'b1;
              end else begin
                // Issue the first read; ST_TAKE then moves the read data to the output register
                rd_en    = 1'b1;
                rd_idx_d = ofbr_pkg::next_idx(rd_idx_q);
                fill_d   = fill_q - FW'(in_i.take_count);
                rem_d    = RW'(in_i.take_count);
                state_d  = ofbr_pkg::ST_TAKE;
              end
            end
            ofbr_pkg::CMD_DROP: begin
              if (fill_q != '0) begin
                rd_idx_d = ofbr_pkg::next_idx(rd_idx_q);
                fill_d   = fill_q - 1'b1;
              end
              load = 1'b1;
            end
            ofbr_pkg::CMD_FLUSH: begin
              rd_idx_d = '0;
              wr_idx_d = '0;
              fill_d   = '0;
              load     = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ofbr_pkg::ST_TAKE: begin
        // Move the pending byte out and read the next one
        if (load_ok) begin
          load    = 1'b1;
          ld_data = rd_data;
          ld_last = (rem_q == RW'(1));
          rem_d   = rem_q - 1'b1;
          if (rem_q != RW'(1)) begin
            rd_en    = 1'b1;
            rd_idx_d = ofbr_pkg::next_idx(rd_idx_q);
          end else begin
            state_d = ofbr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ofbr_pkg::ST_IDLE;
      end
    endcase

    // Fill the output register
    if (load) begin
      out_valid_d = 1'b1;
      out_stat_d  = ld_stat;
      out_data_d  = ld_data;
      out_fill_d  = ofbr_pkg::LEVEL_W'(fill_d);
      out_last_d  = ld_last;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ofbr_pkg::ST_IDLE;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      fill_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_stat_q <= out_stat_d;
    out_data_q <= out_data_d;
    out_fill_q <= out_fill_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_stat_q;
  assign out_o.data_byte  = out_data_q;
  assign out_o.fill_level = out_fill_q;
  assign out_o.last       = out_last_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= ofbr_pkg::DEPTH)
    else $error("fill count above depth");

  a_no_accept_in_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ofbr_pkg::ST_TAKE) |-> !in_i.ready)
    else $error("input taken while a take streams");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == ofbr_pkg::CMD_FLUSH) |=> (fill_q == '0 && rd_idx_q == wr_idx_q))
    else $error("flush left data behind");

  a_take_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ofbr_pkg::ST_TAKE && load_ok && rem_q == RW'(1))
      |=> (state_q == ofbr_pkg::ST_IDLE && out_valid_q && out_last_q))
    else $error("take did not finish with a last byte");
`endif

endmodule
